/* rtl/cst_pkg.sv */
// Shared constants for the M1 closure stress tensor unit.
// Used by the channel interfaces and by the top level; depends on nothing.
package cst_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ENERGY_W = 31;
  localparam int FLUX_W = 32;
  localparam int NUM_PAIRS = 6;

  // Tensor entries in output order: xx, xy, xz, yy, yz, zz.
  localparam int PAIR_I [NUM_PAIRS] = '{0, 0, 0, 1, 1, 2};
  localparam int PAIR_J [NUM_PAIRS] = '{0, 1, 2, 1, 2, 2};

endpackage

/* rtl/cst_in_if.sv */
// Input channel of the M1 closure stress tensor unit: energy density and flux.
// Depends on cst_pkg for field widths.
interface cst_in_if;
  logic                                valid;
  logic                                ready;
  logic [cst_pkg::ENERGY_W-1:0]        energy_density;
  logic signed [cst_pkg::FLUX_W-1:0]   flux_x;
  logic signed [cst_pkg::FLUX_W-1:0]   flux_y;
  logic signed [cst_pkg::FLUX_W-1:0]   flux_z;

  modport source (output valid, energy_density, flux_x, flux_y, flux_z, input ready);
  modport sink (input valid, energy_density, flux_x, flux_y, flux_z, output ready);
endinterface

/* rtl/cst_out_if.sv */
// Output channel of the M1 closure stress tensor unit: ten tensor entries and a flag.
// Depends on cst_pkg for field widths.
interface cst_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [cst_pkg::FLUX_W-1:0]   r_tt;
  logic signed [cst_pkg::FLUX_W-1:0]   r_tx;
  logic signed [cst_pkg::FLUX_W-1:0]   r_ty;
  logic signed [cst_pkg::FLUX_W-1:0]   r_tz;
  logic signed [cst_pkg::FLUX_W-1:0]   r_xx;
  logic signed [cst_pkg::FLUX_W-1:0]   r_xy;
  logic signed [cst_pkg::FLUX_W-1:0]   r_xz;
  logic signed [cst_pkg::FLUX_W-1:0]   r_yy;
  logic signed [cst_pkg::FLUX_W-1:0]   r_yz;
  logic signed [cst_pkg::FLUX_W-1:0]   r_zz;
  logic                                bad_energy;

  modport source (output valid, r_tt, r_tx, r_ty, r_tz, r_xx, r_xy, r_xz, r_yy, r_yz,
                  r_zz, bad_energy, input ready);
  modport sink (input valid, r_tt, r_tx, r_ty, r_tz, r_xx, r_xy, r_xz, r_yy, r_yz,
                r_zz, bad_energy, output ready);
endinterface

/* rtl/cst_delay.sv */
// Delay line with a valid lane, used to keep side data aligned with the long units.
// Depends on nothing.
module cst_delay #(
  parameter int W = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         vin,
  input  logic [W-1:0] d,
  output logic         vout,
  output logic [W-1:0] q
);
  logic [W-1:0] sr [0:DEPTH-1];
  logic [DEPTH-1:0] vr;

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= '0;
    end else if (en) begin
      vr <= DEPTH'({vr, vin});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
        sr[k] <= sr[k-1];
      end
    end
  end

  assign vout = vr[DEPTH-1];
  assign q = sr[DEPTH-1];
endmodule

/* rtl/cst_fdiv.sv */
// Pipelined fraction divider: floor(num * 2^FB / den), capped at 2^FB when num >= den.
// One quotient bit per stage; depends on nothing.
module cst_fdiv #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 64,
  parameter int FB = 16
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [FB:0]      quo
);
  localparam int CMP_W = (NUM_W > DEN_W) ? NUM_W : DEN_W;

  logic [DEN_W-1:0] rem_r [0:FB];
  logic [DEN_W-1:0] den_r [0:FB];
  logic [FB-1:0]    quo_r [0:FB];
  logic [FB:0]      sat_r;
  logic [DEN_W:0]   two_r [0:FB-1];
  logic [FB-1:0]    take;

  always_comb begin
    for (int k = 0; k < FB; k++) begin
      two_r[k] = {rem_r[k], 1'b0};
      take[k] = two_r[k] >= {1'b0, den_r[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DEN_W'(num);
      den_r[0] <= den;
      quo_r[0] <= '0;
      sat_r[0] <= CMP_W'(num) >= CMP_W'(den);
      for (int k = 0; k < FB; k++) begin
        rem_r[k+1] <= take[k] ? DEN_W'(two_r[k] - {1'b0, den_r[k]}) : DEN_W'(two_r[k]);
        den_r[k+1] <= den_r[k];
        quo_r[k+1] <= FB'({quo_r[k], take[k]});
        sat_r[k+1] <= sat_r[k];
      end
    end
  end

  assign quo = sat_r[FB] ? {1'b1, FB'(0)} : {1'b0, quo_r[FB]};
endmodule

/* rtl/cst_isqrt.sv */
// Pipelined integer square root, floor(sqrt(x)), one result bit per stage.
// Depends on nothing.
module cst_isqrt #(
  parameter int XW = 35
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [XW-1:0]          x,
  output logic [(XW+1)/2-1:0]    root
);
  localparam int NQ = (XW + 1) / 2;
  localparam int XP = 2 * NQ;

  logic [XP-1:0]   xi [0:NQ-1];
  logic [NQ-1:0]   rti [0:NQ-1];
  logic [NQ+1:0]   rmi [0:NQ-1];
  logic [XP-1:0]   xo [0:NQ-1];
  logic [NQ-1:0]   rto [0:NQ-1];
  logic [NQ+1:0]   rmo [0:NQ-1];
  logic [NQ+3:0]   rs [0:NQ-1];
  logic [NQ+3:0]   trial [0:NQ-1];
  logic [NQ-1:0]   take;

  always_comb begin
    xi[0] = XP'(x);
    rti[0] = '0;
    rmi[0] = '0;
    for (int k = 1; k < NQ; k++) begin
      xi[k] = xo[k-1];
      rti[k] = rto[k-1];
      rmi[k] = rmo[k-1];
    end
    for (int k = 0; k < NQ; k++) begin
      rs[k] = {rmi[k], xi[k][XP-1-2*k -: 2]};
      trial[k] = {2'b00, rti[k], 2'b01};
      take[k] = rs[k] >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NQ; k++) begin
        xo[k] <= xi[k];
        rto[k] <= NQ'({rti[k], take[k]});
        rmo[k] <= take[k] ? (NQ+2)'(rs[k] - trial[k]) : (NQ+2)'(rs[k]);
      end
    end
  end

  assign root = rto[NQ-1];
endmodule

/* rtl/m1_closure_stress_tensor_unit.sv */
// M1 closure stress tensor unit: Eddington factor, direction products and scaling.
// Depends on cst_pkg, cst_in_if, cst_out_if, cst_delay, cst_fdiv and cst_isqrt.
//
// Usage: in_ch carries one word per cell (energy density, flux x, y, z); out_ch
// carries one word per cell with the ten distinct tensor entries and bad_energy.
// Both channels move a word at a rising edge where valid and ready are high.
// closure_mode is written through cfg_wen and cfg_wdata while the unit is idle:
// 0 selects the M1 variable factor, 1 the fixed factor one third.
// Throughput is one word per cycle while the receiver does not stall.
// The pipeline has 3*FRAC_BITS+14 register stages (62 at the default), set by
// the two bit-serial divider ranks and the square root, each retiring one bit
// per stage.
// Reset clears every valid bit and sets closure_mode to 0.
// When the receiver stalls, the whole pipeline holds and in_ch.ready drops, so no
// word is lost or repeated; it resumes in the cycle the output word is taken.
module m1_closure_stress_tensor_unit #(
  parameter int FRAC_BITS = cst_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wen,
  input  logic       cfg_wdata,
  cst_in_if.sink     in_ch,
  cst_out_if.source  out_ch
);
  import cst_pkg::*;

  localparam int FB = FRAC_BITS;
  localparam int QW = FB + 1;
  localparam int TW = FB + 3;
  localparam int NQ = FB + 2;
  localparam int NW = FB + 3;
  localparam int DW = FB + 4;
  localparam int GW = FB + 3;
  localparam int PW = FB + 2;
  localparam int PRW = GW + PW;
  localparam int CW = FB + 3;
  localparam int EW = FLUX_W + CW;
  localparam longint ONE_L = 64'sd1 << FB;

  typedef struct packed {
    logic [ENERGY_W-1:0]      e;
    logic signed [FLUX_W-1:0] fx;
    logic signed [FLUX_W-1:0] fy;
    logic signed [FLUX_W-1:0] fz;
    logic                     mode;
    logic                     bad;
    logic                     ge;
    logic                     szero;
  } side_t;

  typedef struct packed {
    side_t                              sd;
    logic [QW-1:0]                      m;
    logic [NUM_PAIRS-1:0][QW-1:0]       p;
  } mid_t;

  typedef struct packed {
    side_t                              sd;
    logic [NUM_PAIRS-1:0][QW-1:0]       p;
  } late_t;

  logic adv;
  logic closure_mode;

  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      closure_mode <= 1'b0;
    end else if (cfg_wen) begin
      closure_mode <= cfg_wdata;
    end
  end

  // Input register.
  logic v1;
  side_t s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1.e <= in_ch.energy_density;
      s1.fx <= in_ch.flux_x;
      s1.fy <= in_ch.flux_y;
      s1.fz <= in_ch.flux_z;
      s1.mode <= closure_mode;
      s1.bad <= 1'b0;
      s1.ge <= 1'b0;
      s1.szero <= 1'b0;
    end
  end

  // Squares, cross products and E squared.
  logic [FLUX_W-1:0] fm [0:2];
  logic v2;
  side_t s2;
  logic [63:0] sq2 [0:2];
  logic [63:0] cr2 [0:2];
  logic [2*ENERGY_W-1:0] d2;

  assign fm[0] = s1.fx[FLUX_W-1] ? FLUX_W'(-s1.fx) : FLUX_W'(s1.fx);
  assign fm[1] = s1.fy[FLUX_W-1] ? FLUX_W'(-s1.fy) : FLUX_W'(s1.fy);
  assign fm[2] = s1.fz[FLUX_W-1] ? FLUX_W'(-s1.fz) : FLUX_W'(s1.fz);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2.e <= s1.e;
      s2.fx <= s1.fx;
      s2.fy <= s1.fy;
      s2.fz <= s1.fz;
      s2.mode <= s1.mode;
      s2.bad <= s1.e == '0;
      s2.ge <= s1.ge;
      s2.szero <= s1.szero;
      sq2[0] <= 64'(fm[0]) * 64'(fm[0]);
      sq2[1] <= 64'(fm[1]) * 64'(fm[1]);
      sq2[2] <= 64'(fm[2]) * 64'(fm[2]);
      cr2[0] <= 64'(fm[0]) * 64'(fm[1]);
      cr2[1] <= 64'(fm[0]) * 64'(fm[2]);
      cr2[2] <= 64'(fm[1]) * 64'(fm[2]);
      d2 <= (2*ENERGY_W)'(s1.e) * (2*ENERGY_W)'(s1.e);
    end
  end

  // Flux magnitude squared and its comparison with E squared.
  logic [63:0] ssum;
  logic v3;
  side_t s3;
  logic [63:0] sum3;
  logic [2*ENERGY_W-1:0] d3;
  logic [63:0] n3 [0:NUM_PAIRS-1];

  assign ssum = sq2[0] + sq2[1] + sq2[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3.e <= s2.e;
      s3.fx <= s2.fx;
      s3.fy <= s2.fy;
      s3.fz <= s2.fz;
      s3.mode <= s2.mode;
      s3.bad <= s2.bad;
      s3.ge <= ssum >= 64'(d2);
      s3.szero <= ssum == '0;
      sum3 <= ssum;
      d3 <= d2;
      n3[0] <= sq2[0];
      n3[1] <= cr2[0];
      n3[2] <= cr2[1];
      n3[3] <= sq2[1];
      n3[4] <= cr2[2];
      n3[5] <= sq2[2];
    end
  end

  // First division rank: m = S/D and the six direction products.
  logic [QW-1:0] m_q;
  logic [NUM_PAIRS-1:0][QW-1:0] p_q;
  logic va;
  side_t sa;

  cst_fdiv #(.NUM_W(64), .DEN_W(2*ENERGY_W), .FB(FB)) u_div_m (
    .clk(clk), .en(adv), .num(sum3), .den(d3), .quo(m_q)
  );

  for (genvar k = 0; k < NUM_PAIRS; k++) begin : g_pair_div
    cst_fdiv #(.NUM_W(64), .DEN_W(64), .FB(FB)) u_div_p (
      .clk(clk), .en(adv), .num(n3[k]), .den(sum3), .quo(p_q[k])
    );
  end

  cst_delay #(.W($bits(side_t)), .DEPTH(FB + 1)) u_dly_a (
    .clk(clk), .rst(rst), .en(adv), .vin(v3), .d(s3), .vout(va), .q(sa)
  );

  // t = 4 - 3m ahead of the square root.
  localparam logic [TW-1:0] FOUR_ONE = TW'(4 * ONE_L);
  logic v4;
  logic [TW-1:0] t4;
  mid_t mid4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      t4 <= FOUR_ONE - TW'(3) * TW'(m_q);
      mid4.sd <= sa;
      mid4.m <= m_q;
      mid4.p <= p_q;
    end
  end

  logic [NQ-1:0] root_q;
  logic vb;
  mid_t midb;

  cst_isqrt #(.XW(TW + FB)) u_sqrt (
    .clk(clk), .en(adv), .x({t4, FB'(0)}), .root(root_q)
  );

  cst_delay #(.W($bits(mid_t)), .DEPTH(NQ)) u_dly_b (
    .clk(clk), .rst(rst), .en(adv), .vin(v4), .d(mid4), .vout(vb), .q(midb)
  );

  // Numerator and denominator of the Eddington factor.
  localparam logic [NW-1:0] THREE_ONE = NW'(3 * ONE_L);
  localparam logic [DW-1:0] FIVE_ONE = DW'(5 * ONE_L);
  logic v5;
  logic [NW-1:0] num5;
  logic [DW-1:0] den5;
  late_t late5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num5 <= THREE_ONE + (NW'(midb.m) << 2);
      den5 <= FIVE_ONE + (DW'(root_q) << 1);
      late5.sd <= midb.sd;
      late5.p <= midb.p;
    end
  end

  logic [QW-1:0] f_q;
  logic vc;
  late_t latec;

  cst_fdiv #(.NUM_W(NW), .DEN_W(DW), .FB(FB)) u_div_f (
    .clk(clk), .en(adv), .num(num5), .den(den5), .quo(f_q)
  );

  cst_delay #(.W($bits(late_t)), .DEPTH(FB + 1)) u_dly_c (
    .clk(clk), .rst(rst), .en(adv), .vin(v5), .d(late5), .vout(vc), .q(latec)
  );

  // Factor selection, a = 1 - f, g = 3f - 1, and signed direction products.
  localparam logic [QW-1:0] ONE_Q = QW'(ONE_L);
  localparam logic [QW-1:0] THIRD_Q = QW'(ONE_L / 3);
  logic [QW-1:0] fsel;
  logic signed [GW-1:0] fs;
  logic [2:0] fsign;
  logic signed [PW-1:0] sp [0:NUM_PAIRS-1];
  logic v6;
  side_t s6;
  logic signed [GW-1:0] a6;
  logic signed [GW-1:0] g6;
  logic signed [PW-1:0] sp6 [0:NUM_PAIRS-1];

  always_comb begin
    if (latec.sd.mode) begin
      fsel = THIRD_Q;
    end else if (latec.sd.ge) begin
      fsel = ONE_Q;
    end else begin
      fsel = f_q;
    end
    fs = $signed(GW'(fsel));
    fsign = {latec.sd.fz[FLUX_W-1], latec.sd.fy[FLUX_W-1], latec.sd.fx[FLUX_W-1]};
    for (int k = 0; k < NUM_PAIRS; k++) begin
      if (latec.sd.szero) begin
        sp[k] = '0;
      end else if (fsign[PAIR_I[k]] ^ fsign[PAIR_J[k]]) begin
        sp[k] = -$signed(PW'(latec.p[k]));
      end else begin
        sp[k] = $signed(PW'(latec.p[k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= vc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6 <= latec.sd;
      a6 <= $signed(GW'(ONE_L)) - fs;
      g6 <= GW'(3) * fs - $signed(GW'(ONE_L));
      for (int k = 0; k < NUM_PAIRS; k++) begin
        sp6[k] <= sp[k];
      end
    end
  end

  // g times the direction product.
  logic v7;
  side_t s7;
  logic signed [GW-1:0] a7;
  logic signed [PRW-1:0] prod7 [0:NUM_PAIRS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s7 <= s6;
      a7 <= a6;
      for (int k = 0; k < NUM_PAIRS; k++) begin
        prod7[k] <= PRW'(g6) * PRW'(sp6[k]);
      end
    end
  end

  // c = a on the diagonal plus floor(g * p / ONE).
  logic v8;
  side_t s8;
  logic signed [CW-1:0] c8 [0:NUM_PAIRS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s8 <= s7;
      for (int k = 0; k < NUM_PAIRS; k++) begin
        c8[k] <= CW'(prod7[k] >>> FB) + ((PAIR_I[k] == PAIR_J[k]) ? a7 : '0);
      end
    end
  end

  // E times c.
  logic v9;
  side_t s9;
  logic signed [EW-1:0] ec9 [0:NUM_PAIRS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (adv) begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s9 <= s8;
      for (int k = 0; k < NUM_PAIRS; k++) begin
        ec9[k] <= EW'($signed({1'b0, s8.e})) * EW'(c8[k]);
      end
    end
  end

  // Halving shift, saturation and the output register.
  logic signed [EW-1:0] sh [0:NUM_PAIRS-1];
  logic signed [FLUX_W-1:0] rs [0:NUM_PAIRS-1];

  always_comb begin
    for (int k = 0; k < NUM_PAIRS; k++) begin
      sh[k] = ec9[k] >>> (FB + 1);
      if (sh[k][EW-1:FLUX_W-1] == '0 || sh[k][EW-1:FLUX_W-1] == '1) begin
        rs[k] = sh[k][FLUX_W-1:0];
      end else if (sh[k][EW-1]) begin
        rs[k] = {1'b1, (FLUX_W-1)'(0)};
      end else begin
        rs[k] = {1'b0, {(FLUX_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.bad_energy <= s9.bad;
      out_ch.r_tt <= s9.bad ? '0 : FLUX_W'(s9.e);
      out_ch.r_tx <= s9.bad ? '0 : s9.fx;
      out_ch.r_ty <= s9.bad ? '0 : s9.fy;
      out_ch.r_tz <= s9.bad ? '0 : s9.fz;
      out_ch.r_xx <= s9.bad ? '0 : rs[0];
      out_ch.r_xy <= s9.bad ? '0 : rs[1];
      out_ch.r_xz <= s9.bad ? '0 : rs[2];
      out_ch.r_yy <= s9.bad ? '0 : rs[3];
      out_ch.r_yz <= s9.bad ? '0 : rs[4];
      out_ch.r_zz <= s9.bad ? '0 : rs[5];
    end
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.bad_energy |-> out_ch.r_tt == '0 && out_ch.r_xx == '0
      && out_ch.r_zz == '0)
    else $error("bad energy word carries nonzero entries");

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("output valid right after reset");

  a_last_stage: assert property (@(posedge clk) disable iff (rst)
    v9 && adv |=> out_ch.valid)
    else $error("word in last stage did not reach the output register");

endmodule

/* tb/cst_tb_checker.sv */
// Scoreboard for the M1 closure stress tensor unit: tracks closure_mode, predicts the
// tensor for every accepted input word and compares it with the output words.
// Depends on cst_pkg, cst_in_if and cst_out_if.
module cst_tb_checker (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wen,
  input  logic cfg_wdata,
  cst_in_if    in_ch,
  cst_out_if   out_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = cst_pkg::FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FB;

  typedef struct {
    logic signed [31:0] tt, tx, ty, tz, xx, xy, xz, yy, yz, zz;
    logic               bad;
  } tensor_t;

  tensor_t tensor_q[$];
  logic    mode;

  function automatic logic [63:0] unit_ratio(logic [63:0] num, logic [63:0] den);
    logic [63:0] q, r;
    q = 0;
    r = num;
    if (r >= den) return 64'(ONE);
    for (int i = 0; i < FB; i++) begin
      q = q << 1;
      if (r >= den - r) begin
        r = r - (den - r);
        q = q | 1;
      end else begin
        r = r << 1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic tensor_t predict_tensor(logic [30:0] e_in, logic signed [31:0] fx,
                                             logic signed [31:0] fy,
                                             logic signed [31:0] fz, logic fixed_mode);
    tensor_t     t;
    longint      fl[3];
    logic [63:0] fm[3];
    logic [63:0] s, d, m, tq, q, num, den;
    longint      e, f, a, g, p, tot, c;
    longint      spatial[6];
    e = longint'(e_in);
    fl[0] = fx;
    fl[1] = fy;
    fl[2] = fz;
    t = '{default: '0};
    if (e == 0) begin
      t.bad = 1'b1;
      return t;
    end
    for (int k = 0; k < 3; k++) fm[k] = (fl[k] < 0) ? -fl[k] : fl[k];
    s = fm[0] * fm[0] + fm[1] * fm[1] + fm[2] * fm[2];
    d = e * e;
    if (fixed_mode) begin
      f = ONE / 3;
    end else if (s >= d) begin
      f = ONE;
    end else begin
      m = unit_ratio(s, d);
      tq = 4 * ONE - 3 * m;
      q = int_sqrt(tq << FB);
      num = 3 * ONE + 4 * m;
      den = 5 * ONE + 2 * q;
      f = longint'((num << FB) / den);
    end
    a = ONE - f;
    g = 3 * f - ONE;
    for (int k = 0; k < cst_pkg::NUM_PAIRS; k++) begin
      p = 0;
      if (s != 0) begin
        p = longint'(unit_ratio(fm[cst_pkg::PAIR_I[k]] * fm[cst_pkg::PAIR_J[k]], s));
        if ((fl[cst_pkg::PAIR_I[k]] < 0) != (fl[cst_pkg::PAIR_J[k]] < 0)) p = -p;
      end
      tot = g * p;
      if (cst_pkg::PAIR_I[k] == cst_pkg::PAIR_J[k]) tot += a * ONE;
      c = tot >>> FB;
      spatial[k] = (e * c) >>> (FB + 1);
    end
    t.tt = {1'b0, e_in};
    t.tx = fx;
    t.ty = fy;
    t.tz = fz;
    t.xx = clamp32(spatial[0]);
    t.xy = clamp32(spatial[1]);
    t.xz = clamp32(spatial[2]);
    t.yy = clamp32(spatial[3]);
    t.yz = clamp32(spatial[4]);
    t.zz = clamp32(spatial[5]);
    return t;
  endfunction

  function automatic void check_entry(string name, logic signed [31:0] exp_v,
                                      logic signed [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  initial fail_count = 0;
  assign pending = tensor_q.size();

  always @(posedge clk) begin
    tensor_t w;
    if (rst) begin
      mode <= 1'b0;
    end else begin
      if (cfg_wen) mode <= cfg_wdata;
      if (in_ch.valid && in_ch.ready)
        tensor_q.push_back(predict_tensor(in_ch.energy_density, in_ch.flux_x,
                                          in_ch.flux_y, in_ch.flux_z, mode));
      if (out_ch.valid && out_ch.ready) begin
        if (tensor_q.size() == 0) begin
          $error("output word with no prediction waiting");
          fail_count++;
        end else begin
          w = tensor_q.pop_front();
          check_entry("r_tt", w.tt, out_ch.r_tt);
          check_entry("r_tx", w.tx, out_ch.r_tx);
          check_entry("r_ty", w.ty, out_ch.r_ty);
          check_entry("r_tz", w.tz, out_ch.r_tz);
          check_entry("r_xx", w.xx, out_ch.r_xx);
          check_entry("r_xy", w.xy, out_ch.r_xy);
          check_entry("r_xz", w.xz, out_ch.r_xz);
          check_entry("r_yy", w.yy, out_ch.r_yy);
          check_entry("r_yz", w.yz, out_ch.r_yz);
          check_entry("r_zz", w.zz, out_ch.r_zz);
          check_entry("bad_energy", 32'(w.bad), 32'(out_ch.bad_energy));
        end
      end
    end
  end
endmodule

/* tb/tb_m1_closure_stress_tensor_unit.sv */
// Top of the testbench for m1_closure_stress_tensor_unit: clock, reset, closure_mode
// writes, bursty stimulus, receiver stalls, watchdog and verdict.
// Depends on cst_pkg, cst_in_if, cst_out_if, the unit and cst_tb_checker.
module tb_m1_closure_stress_tensor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 3 * cst_pkg::FRAC_BITS_DEF + 14;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ONE = 1 << cst_pkg::FRAC_BITS_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wen = 1'b0;
  logic cfg_wdata = 1'b0;
  int   fail_count, pending;
  int   idle_cycles = 0;
  int   sent = 0;
  int   burst_left = 0;
  int   cycle_no = 0;
  int   total_seen = 0;

  cst_in_if  in_if ();
  cst_out_if out_if ();

  m1_closure_stress_tensor_unit u_top (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_ch(in_if), .out_ch(out_if)
  );

  cst_tb_checker u_checker (
    .clk(clk), .rst(rst), .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_ch(in_if), .out_ch(out_if), .fail_count(fail_count), .pending(pending)
  );

  always #4 clk = ~clk;

  initial begin
    in_if.valid = 1'b0;
    in_if.energy_density = '0;
    in_if.flux_x = '0;
    in_if.flux_y = '0;
    in_if.flux_z = '0;
    out_if.ready = 1'b0;
  end

  // The receiver mixes free running, random stalls and one long hold-off.
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      cycle_no++;
      if (!held && sent >= 100) begin
        hold = 400;
        held = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else if ((cycle_no / 300) % 3 == 0) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("FAIL m1_closure_stress_tensor_unit");
        $finish;
      end
    end
    if (out_if.valid && out_if.ready) total_seen <= total_seen + 1;
  end

  task automatic send_word(logic [30:0] e, logic signed [31:0] fx,
                           logic signed [31:0] fy, logic signed [31:0] fz);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_if.valid <= 1'b1;
    in_if.energy_density <= e;
    in_if.flux_x <= fx;
    in_if.flux_y <= fy;
    in_if.flux_z <= fz;
    do @(negedge clk); while (!in_if.ready);
    @(posedge clk);
    sent++;
  endtask

  task automatic write_mode(logic value);
    in_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  function automatic logic signed [31:0] scaled_flux(logic [30:0] e);
    logic signed [63:0] v;
    v = $signed({1'b0, e}) * $signed(33'($urandom_range(0, 1100))) / 1000;
    if ($urandom_range(0, 1)) v = -v;
    return v[31:0];
  endfunction

  task automatic random_words(int n);
    logic [30:0] e;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 19);
      e = (sel < 12) ? 31'($urandom_range(1, 64 * ONE)) : 31'($urandom);
      if (sel == 19) begin
        send_word('0, $urandom, $urandom, $urandom);
      end else if (sel == 18) begin
        send_word(e, '0, '0, '0);
      end else if (sel >= 15) begin
        send_word(31'($urandom), $urandom, $urandom, $urandom);
      end else begin
        send_word(e, scaled_flux(e) / 2, scaled_flux(e) / 2, scaled_flux(e) / 2);
      end
    end
  endtask

  task automatic directed_words();
    send_word('0, '0, '0, '0);
    send_word('0, 32'sh7fffffff, -32'sh80000000, 32'sd5);
    send_word(31'h7fffffff, '0, '0, '0);
    send_word(31'd1, '0, '0, '0);
    send_word(31'd1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_word(31'd1, -32'sh80000000, -32'sh80000000, -32'sh80000000);
    send_word(31'h7fffffff, 32'sh7fffffff, -32'sh80000000, 32'sh7fffffff);
    send_word(31'h7fffffff, -32'sh80000000, '0, '0);
    send_word(31'(ONE), 32'(ONE), '0, '0);
    send_word(31'(ONE), '0, -32'(ONE), '0);
    send_word(31'(ONE), '0, '0, 32'(ONE / 2));
    send_word(31'(ONE), 32'(ONE / 4), -32'(ONE / 4), 32'(ONE / 4));
    send_word(31'(ONE), 32'd1, '0, '0);
    send_word(31'(2 * ONE), -32'(ONE), 32'(ONE), -32'(ONE));
    send_word(31'(3 * ONE), 32'(ONE), 32'(2 * ONE), 32'(2 * ONE));
    send_word(31'h7fffffff, 32'sh40000000, 32'sh40000000, -32'sh40000000);
    send_word(31'h55555555, 32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa);
    send_word(31'd100, 32'sd99, -32'sd1, 32'sd0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_mode(1'b0);
    directed_words();
    random_words(150);
    write_mode(1'b1);
    directed_words();
    random_words(130);
    write_mode(1'b0);
    random_words(150);
    write_mode(1'b1);
    random_words(60);
    write_mode(1'b0);
    random_words(60);
    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    $display("Sent %0d words and checked %0d results over both closure modes,",
             sent, total_seen);
    $display("including zero energy, zero flux, saturation and a long receiver hold-off.");
    if (fail_count == 0) begin
      $display("PASS m1_closure_stress_tensor_unit");
    end else begin
      $display("FAIL m1_closure_stress_tensor_unit");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/cst_pkg.sv
rtl/cst_in_if.sv
rtl/cst_out_if.sv
rtl/cst_delay.sv
rtl/cst_fdiv.sv
rtl/cst_isqrt.sv
rtl/m1_closure_stress_tensor_unit.sv
tb/cst_tb_checker.sv
tb/tb_m1_closure_stress_tensor_unit.sv
